[sv/bit_select_sampled_index_assert.svh]
// Assertion macros for the bit select engine.
// Used by bssi_ctrl; needs nothing else.
`ifndef BIT_SELECT_SAMPLED_INDEX_ASSERT_SVH
`define BIT_SELECT_SAMPLED_INDEX_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BSSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BSSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bssi_pkg.sv]
// Shared types and constants for the bit select engine.
// No dependencies; used by every other file but the assertion macro header.
package bssi_pkg;

   localparam int MAX_BITS     = 4096;
   localparam int SAMPLE_EVERY = 8;
   localparam int POS_W        = 12;
   localparam int CNT_W        = 13;
   localparam int RANK_W       = 13;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic              bit_value;
      logic              desired_value;
      logic [RANK_W-1:0] rank;
   } req_beat_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_beat_type;

   // Memory control from sequencer to store.
   typedef struct packed {
      logic             bit_we;
      logic [POS_W-1:0] bit_wr_addr;
      logic             bit_wr_data;
      logic             zero_samp_we;
      logic             one_samp_we;
      logic [POS_W-1:0] samp_wr_slot;
      logic [POS_W-1:0] samp_wr_pos;
      logic [POS_W-1:0] bit_rd_addr;
      logic [POS_W-1:0] samp_rd_slot;
   } mem_ctl_type;

   // Registered read data from the store.
   typedef struct packed {
      logic             bit_rd;
      logic [POS_W-1:0] zero_samp;
      logic [POS_W-1:0] one_samp;
   } mem_rd_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } res_type;

endpackage

[sv/bssi_store.sv]
// Bit store and the two sample tables, one write and one registered read each.
// Depends on bssi_pkg.
module bssi_store #(
   parameter int SAMPLE_EVERY = bssi_pkg::SAMPLE_EVERY
) (
   input  logic                 clock,
   input  bssi_pkg::mem_ctl_type mem_ctl,
   output bssi_pkg::mem_rd_type  mem_rd
);

   localparam int SLOTS  = (bssi_pkg::MAX_BITS + SAMPLE_EVERY - 1) / SAMPLE_EVERY;
   localparam int SLOT_W = $clog2(SLOTS);

   logic                       bit_mem [bssi_pkg::MAX_BITS];
   logic [bssi_pkg::POS_W-1:0] zero_samp_mem [SLOTS];
   logic [bssi_pkg::POS_W-1:0] one_samp_mem [SLOTS];

   logic                       bit_rd_ff;
   logic [bssi_pkg::POS_W-1:0] zero_samp_ff;
   logic [bssi_pkg::POS_W-1:0] one_samp_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.bit_we) begin
         bit_mem[mem_ctl.bit_wr_addr] <= mem_ctl.bit_wr_data;
      end
      bit_rd_ff <= bit_mem[mem_ctl.bit_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.zero_samp_we) begin
         zero_samp_mem[mem_ctl.samp_wr_slot[SLOT_W-1:0]] <= mem_ctl.samp_wr_pos;
      end
      zero_samp_ff <= zero_samp_mem[mem_ctl.samp_rd_slot[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.one_samp_we) begin
         one_samp_mem[mem_ctl.samp_wr_slot[SLOT_W-1:0]] <= mem_ctl.samp_wr_pos;
      end
      one_samp_ff <= one_samp_mem[mem_ctl.samp_rd_slot[SLOT_W-1:0]];
   end

   assign mem_rd.bit_rd    = bit_rd_ff;
   assign mem_rd.zero_samp = zero_samp_ff;
   assign mem_rd.one_samp  = one_samp_ff;

endmodule

[sv/bssi_ctrl.sv]
// Sequencer: clear, counts and sample bookkeeping on append, rank split and bit scan on query.
// Depends on bssi_pkg and bit_select_sampled_index_assert.svh.
`include "bit_select_sampled_index_assert.svh"

module bssi_ctrl #(
   parameter int SAMPLE_EVERY = bssi_pkg::SAMPLE_EVERY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  bssi_pkg::req_beat_type req_data,
   output logic                  idle,
   output bssi_pkg::mem_ctl_type mem_ctl,
   input  bssi_pkg::mem_rd_type   mem_rd,
   output bssi_pkg::res_type      res,
   input  logic                  res_take
);

   localparam int POS_W      = bssi_pkg::POS_W;
   localparam int CNT_W      = bssi_pkg::CNT_W;
   localparam int RANK_W     = bssi_pkg::RANK_W;
   localparam int SLOTS      = (bssi_pkg::MAX_BITS + SAMPLE_EVERY - 1) / SAMPLE_EVERY;
   localparam int SLOT_CNT_W = $clog2(SLOTS + 1);
   localparam int LEFT_W     = $clog2(SAMPLE_EVERY + 1);
   // reciprocal for the rank split: q = (r * RECIP) >> SHIFT
   localparam int SHIFT      = POS_W + $clog2(SAMPLE_EVERY) + 1;
   localparam int RECIP      = (2 ** SHIFT + SAMPLE_EVERY - 1) / SAMPLE_EVERY;
   localparam int RECIP_W    = SHIFT + 1;
   localparam int PROD_W     = POS_W + RECIP_W;
   localparam int MUL_W      = POS_W + LEFT_W + 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_REM  = 6'b000100,
      S_SAMP = 6'b001000,
      S_SCAN = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      bit_count_ff, bit_count_in;
   logic [CNT_W-1:0]      zero_count_ff, zero_count_in;
   logic [CNT_W-1:0]      one_count_ff, one_count_in;
   logic [LEFT_W-1:0]     zero_phase_ff, zero_phase_in;
   logic [LEFT_W-1:0]     one_phase_ff, one_phase_in;
   logic [SLOT_CNT_W-1:0] zero_slot_ff, zero_slot_in;
   logic [SLOT_CNT_W-1:0] one_slot_ff, one_slot_in;
   logic                  want_ff, want_in;
   logic [POS_W-1:0]      rm1_ff, rm1_in;
   logic [POS_W-1:0]      q_ff, q_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic [CNT_W-1:0]      scan_addr_ff, scan_addr_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [POS_W-1:0]      rd_pos_ff, rd_pos_in;
   logic                  found_ff, found_in;
   logic [POS_W-1:0]      pos_ff, pos_in;

   logic [RANK_W-1:0] rank_m1;
   logic [CNT_W-1:0]  total;
   logic [PROD_W-1:0] div_prod;
   logic [MUL_W-1:0]  qd;
   logic [MUL_W-1:0]  rem_raw;
   logic              rem_over;
   logic [POS_W-1:0]  slot_fix;
   logic [MUL_W-1:0]  rem_fix;
   logic [POS_W-1:0]  samp;
   logic              issue;

   assign rank_m1  = req_data.rank - RANK_W'(1);
   assign total    = req_data.desired_value ? one_count_ff : zero_count_ff;
   assign div_prod = PROD_W'(rm1_ff) * PROD_W'(RECIP);
   assign qd       = MUL_W'(q_ff) * MUL_W'(SAMPLE_EVERY);
   assign rem_raw  = MUL_W'(rm1_ff) - qd;
   // the reciprocal may leave the quotient one short
   assign rem_over = rem_raw >= MUL_W'(SAMPLE_EVERY);
   assign slot_fix = rem_over ? q_ff + POS_W'(1) : q_ff;
   assign rem_fix  = rem_over ? rem_raw - MUL_W'(SAMPLE_EVERY) : rem_raw;
   assign samp     = want_ff ? mem_rd.one_samp : mem_rd.zero_samp;
   assign issue    = scan_addr_ff < bit_count_ff;

   always_comb begin
      state_in      = state_ff;
      bit_count_in  = bit_count_ff;
      zero_count_in = zero_count_ff;
      one_count_in  = one_count_ff;
      zero_phase_in = zero_phase_ff;
      one_phase_in  = one_phase_ff;
      zero_slot_in  = zero_slot_ff;
      one_slot_in   = one_slot_ff;
      want_in       = want_ff;
      rm1_in        = rm1_ff;
      q_in          = q_ff;
      left_in       = left_ff;
      scan_addr_in  = scan_addr_ff;
      rd_vld_in     = 1'b0;
      rd_pos_in     = scan_addr_ff[POS_W-1:0];
      found_in      = found_ff;
      pos_in        = pos_ff;

      mem_ctl              = '0;
      mem_ctl.bit_wr_addr  = bit_count_ff[POS_W-1:0];
      mem_ctl.bit_wr_data  = req_data.bit_value;
      mem_ctl.samp_wr_pos  = bit_count_ff[POS_W-1:0];
      mem_ctl.bit_rd_addr  = scan_addr_ff[POS_W-1:0];
      mem_ctl.samp_rd_slot = slot_fix;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.req_type)
                  bssi_pkg::REQ_CLEAR: begin
                     bit_count_in  = '0;
                     zero_count_in = '0;
                     one_count_in  = '0;
                     zero_phase_in = '0;
                     one_phase_in  = '0;
                     zero_slot_in  = '0;
                     one_slot_in   = '0;
                  end
                  bssi_pkg::REQ_APPEND: begin
                     if (bit_count_ff < CNT_W'(bssi_pkg::MAX_BITS)) begin
                        mem_ctl.bit_we = 1'b1;
                        bit_count_in   = bit_count_ff + CNT_W'(1);
                        if (req_data.bit_value) begin
                           one_count_in = one_count_ff + CNT_W'(1);
                           if (one_phase_ff == '0) begin
                              mem_ctl.one_samp_we  = 1'b1;
                              mem_ctl.samp_wr_slot = POS_W'(one_slot_ff);
                              one_slot_in          = one_slot_ff + SLOT_CNT_W'(1);
                           end
                           one_phase_in = (one_phase_ff == LEFT_W'(SAMPLE_EVERY - 1)) ?
                                          '0 : one_phase_ff + LEFT_W'(1);
                        end else begin
                           zero_count_in = zero_count_ff + CNT_W'(1);
                           if (zero_phase_ff == '0) begin
                              mem_ctl.zero_samp_we = 1'b1;
                              mem_ctl.samp_wr_slot = POS_W'(zero_slot_ff);
                              zero_slot_in         = zero_slot_ff + SLOT_CNT_W'(1);
                           end
                           zero_phase_in = (zero_phase_ff == LEFT_W'(SAMPLE_EVERY - 1)) ?
                                           '0 : zero_phase_ff + LEFT_W'(1);
                        end
                     end
                  end
                  bssi_pkg::REQ_QUERY: begin
                     want_in = req_data.desired_value;
                     if (req_data.rank == '0 || req_data.rank > total) begin
                        found_in = 1'b0;
                        pos_in   = '0;
                        state_in = S_DONE;
                     end else begin
                        rm1_in   = rank_m1[POS_W-1:0];
                        state_in = S_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            q_in     = div_prod[SHIFT +: POS_W];
            state_in = S_REM;
         end
         S_REM: begin
            // sample read issued here, data back in S_SAMP
            left_in  = LEFT_W'(rem_fix);
            state_in = S_SAMP;
         end
         S_SAMP: begin
            if (left_ff == '0) begin
               found_in = 1'b1;
               pos_in   = samp;
               state_in = S_DONE;
            end else begin
               scan_addr_in = CNT_W'(samp) + CNT_W'(1);
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // one bit read issued per cycle, checked the cycle after
            rd_vld_in = issue;
            if (issue) begin
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            if (rd_vld_ff && mem_rd.bit_rd == want_ff) begin
               if (left_ff == LEFT_W'(1)) begin
                  found_in = 1'b1;
                  pos_in   = rd_pos_ff;
                  state_in = S_DONE;
               end else begin
                  left_in = left_ff - LEFT_W'(1);
               end
            end else if (!rd_vld_ff && !issue) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bit_count_ff  <= '0;
         zero_count_ff <= '0;
         one_count_ff  <= '0;
         zero_phase_ff <= '0;
         one_phase_ff  <= '0;
         zero_slot_ff  <= '0;
         one_slot_ff   <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_count_ff  <= bit_count_in;
         zero_count_ff <= zero_count_in;
         one_count_ff  <= one_count_in;
         zero_phase_ff <= zero_phase_in;
         one_phase_ff  <= one_phase_in;
         zero_slot_ff  <= zero_slot_in;
         one_slot_ff   <= one_slot_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      rm1_ff       <= rm1_in;
      q_ff         <= q_in;
      left_ff      <= left_in;
      scan_addr_ff <= scan_addr_in;
      rd_pos_ff    <= rd_pos_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
   end

   assign idle          = state_ff == S_IDLE;
   assign res.valid     = state_ff == S_DONE;
   assign res.beat.found    = found_ff;
   assign res.beat.position = pos_ff;

   `BSSI_ASSERT_NOW(a_count_sum, clock, reset, 1'b1, (CNT_W+1)'(bit_count_ff) == (CNT_W+1)'(zero_count_ff) + (CNT_W+1)'(one_count_ff), "bit count differs from zero plus one counts")
   `BSSI_ASSERT_NOW(a_count_max, clock, reset, 1'b1, bit_count_ff <= CNT_W'(bssi_pkg::MAX_BITS), "bit count beyond store size")
   `BSSI_ASSERT_NOW(a_scan_left, clock, reset, state_ff == S_SCAN, left_ff != '0, "scan running with nothing left to find")
   `BSSI_ASSERT_NOW(a_scan_addr, clock, reset, state_ff == S_SCAN, scan_addr_ff <= bit_count_ff, "scan address past the stored bits")
   `BSSI_ASSERT_NEXT(a_done_hold, clock, reset, state_ff == S_DONE && !res_take, state_ff == S_DONE, "result dropped before it was taken")

endmodule

[sv/bit_select_sampled_index.sv]
// Select engine over an appended bit vector: top level with the result register.
// Depends on bssi_pkg, bssi_store and bssi_ctrl.
//
// Input channel (req_valid/req_ready/req_data) carries one request per beat:
// clear the store, append one bit, or ask for the position of the rank-th
// zero or one (ranks count from one). Clear and append give no result beat;
// each query gives exactly one beat on rsp_valid/rsp_ready/rsp_data, with
// found low and position zero when the occurrence does not exist.
// req_ready stays high through clear, append and an ignored code. A query
// with rank zero or above the count goes straight to the done state.
// Otherwise the rank is split into a sample slot and an offset (S_DIV, S_REM),
// the sample is read (issued in S_REM, data back in S_SAMP), and then the bit
// memory is scanned one stored bit per cycle through its registered read. The
// scan is skipped when the sample is the answer, else it runs up to the
// (SAMPLE_EVERY - 1)-th further hit, however many bits lie between hits.
// req_ready is low while a query is in flight. A finished result waits in the
// output register; a new request is still taken meanwhile, and a further
// query holds in its last step until the receiver takes the waiting beat.
// Synchronous reset empties the store and drops any pending result.
module bit_select_sampled_index #(
   parameter int SAMPLE_EVERY = bssi_pkg::SAMPLE_EVERY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bssi_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bssi_pkg::rsp_beat_type rsp_data
);

   bssi_pkg::mem_ctl_type mem_ctl;
   bssi_pkg::mem_rd_type  mem_rd;
   bssi_pkg::res_type     res;
   logic                  idle;
   logic                  res_take;

   logic                   rsp_valid_ff, rsp_valid_in;
   bssi_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;

   bssi_store #(
      .SAMPLE_EVERY (SAMPLE_EVERY)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .mem_rd  (mem_rd)
   );

   bssi_ctrl #(
      .SAMPLE_EVERY (SAMPLE_EVERY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .idle      (idle),
      .mem_ctl   (mem_ctl),
      .mem_rd    (mem_rd),
      .res       (res),
      .res_take  (res_take)
   );

   // output register is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/bssi_select_checker.sv]
// Scoreboard for the bit select engine: watches both channels, keeps its own copy
// of the bit vector and the sampled positions, and checks every result beat.
// Depends on bssi_pkg.
module bssi_select_checker
   import bssi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_beat_type rsp_data,
   output int           mismatches,
   output int           answers_pending
);

   localparam int SLOTS = (MAX_BITS + SAMPLE_EVERY - 1) / SAMPLE_EVERY;

   logic         stored_bits [MAX_BITS];
   int           zero_marks [SLOTS];
   int           one_marks [SLOTS];
   int           n_bits;
   int           n_zeros;
   int           n_ones;
   rsp_beat_type answers_due [$];

   initial begin
      mismatches      = 0;
      answers_pending = 0;
      n_bits          = 0;
      n_zeros         = 0;
      n_ones          = 0;
   end

   always @(posedge clock) begin : track
      rsp_beat_type due;
      rsp_beat_type answer;
      logic         want;
      int           rank;
      int           total;
      int           slot;
      int           left;
      int           p;

      if (reset) begin
         n_bits  = 0;
         n_zeros = 0;
         n_ones  = 0;
         answers_due.delete();
      end else begin
         // result side first: a beat leaving now always belongs to an older query
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: found=%0b position=%0d",
                           rsp_data.found, rsp_data.position);
            end else begin
               due = answers_due.pop_front();
               if (rsp_data.found !== due.found || rsp_data.position !== due.position) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                              due.found, due.position, rsp_data.found, rsp_data.position);
               end
            end
         end

         if (req_valid && req_ready) begin
            case (req_data.req_type)
               REQ_CLEAR: begin
                  n_bits  = 0;
                  n_zeros = 0;
                  n_ones  = 0;
               end
               REQ_APPEND: begin
                  // a full store drops the bit silently
                  if (n_bits < MAX_BITS) begin
                     stored_bits[n_bits] = req_data.bit_value;
                     if (req_data.bit_value) begin
                        n_ones++;
                        if ((n_ones - 1) % SAMPLE_EVERY == 0)
                           one_marks[(n_ones - 1) / SAMPLE_EVERY] = n_bits;
                     end else begin
                        n_zeros++;
                        if ((n_zeros - 1) % SAMPLE_EVERY == 0)
                           zero_marks[(n_zeros - 1) / SAMPLE_EVERY] = n_bits;
                     end
                     n_bits++;
                  end
               end
               REQ_QUERY: begin
                  answer = '0;
                  want   = req_data.desired_value;
                  rank   = int'(req_data.rank);
                  total  = want ? n_ones : n_zeros;
                  if (rank != 0 && rank <= total) begin
                     slot = (rank - 1) / SAMPLE_EVERY;
                     left = (rank - 1) % SAMPLE_EVERY;
                     p    = want ? one_marks[slot] : zero_marks[slot];
                     // walk on from the sampled position to the wanted occurrence
                     while (left > 0 && p + 1 < n_bits) begin
                        p++;
                        if (stored_bits[p] == want)
                           left--;
                     end
                     if (left == 0) begin
                        answer.found    = 1'b1;
                        answer.position = p[POS_W-1:0];
                     end
                  end
                  answers_due.push_back(answer);
               end
               default: ;
            endcase
         end
         answers_pending = answers_due.size();
      end
   end

endmodule

[verif/bit_select_sampled_index_tb.sv]
// Testbench top for the bit select engine: clock, reset, request and result
// traffic, watchdog and verdict. Depends on bssi_pkg, the block and bssi_select_checker.
module bit_select_sampled_index_tb;
   import bssi_pkg::*;

   localparam logic [1:0] REQ_IGNORED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1300;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         DRAIN_CYCLES = SAMPLE_EVERY + 12;
   localparam logic [15:0] OPENING_BITS = 16'b1001_0111_1011_1011;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   int           mismatches;
   int           answers_pending;

   // stimulus-side view of the vector, only used to aim ranks
   int           vec_len    = 0;
   int           zeros_held = 0;
   int           ones_held  = 0;
   bit           steady        = 1'b0;
   bit           hold_off_due  = 1'b0;
   bit           hold_off_done = 1'b0;

   always #4 clock = ~clock;

   bit_select_sampled_index dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bssi_select_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatches      (mismatches),
      .answers_pending (answers_pending)
   );

   // Holds valid and payload until the beat is taken; valid stays up into
   // the next beat unless a gap is drawn.
   task automatic send_beat(input req_beat_type beat);
      if (!steady) begin
         while ($urandom_range(99) < 18) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic offer(input logic [1:0] kind, input logic bit_in, input logic want,
                        input int rank);
      req_beat_type beat;
      beat.req_type      = kind;
      beat.bit_value     = bit_in;
      beat.desired_value = want;
      beat.rank          = rank[RANK_W-1:0];
      case (kind)
         REQ_CLEAR: begin
            vec_len    = 0;
            zeros_held = 0;
            ones_held  = 0;
         end
         REQ_APPEND: begin
            if (vec_len < MAX_BITS) begin
               vec_len++;
               if (bit_in)
                  ones_held++;
               else
                  zeros_held++;
            end
         end
         default: ;
      endcase
      send_beat(beat);
   endtask

   initial begin : stimulus
      int done;
      int pick;
      int ones_bias;
      int total;
      logic want;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty store, rank zero
      offer(REQ_QUERY, 1'b1, 1'b1, 1);
      offer(REQ_QUERY, 1'b0, 1'b0, 0);
      for (int i = 0; i < 16; i++)
         offer(REQ_APPEND, OPENING_BITS[i], 1'($urandom_range(1)), $urandom_range(MAX_BITS));
      // sample hits, scans of two, four and seven further hits, the second slot, above the count
      offer(REQ_QUERY, 1'b0, 1'b1, 1);
      offer(REQ_QUERY, 1'b1, 1'b1, 3);
      offer(REQ_QUERY, 1'b0, 1'b1, 8);
      offer(REQ_QUERY, 1'b1, 1'b1, 9);
      offer(REQ_QUERY, 1'b0, 1'b1, ones_held);
      offer(REQ_QUERY, 1'b1, 1'b1, ones_held + 1);
      offer(REQ_QUERY, 1'b0, 1'b0, zeros_held);
      offer(REQ_QUERY, 1'b1, 1'b0, zeros_held + 1);
      offer(REQ_QUERY, 1'b1, 1'b1, 0);
      offer(REQ_IGNORED, 1'b1, 1'b1, MAX_BITS);
      offer(REQ_CLEAR, 1'b1, 1'b0, 5);
      offer(REQ_QUERY, 1'b0, 1'b1, 1);
      offer(REQ_APPEND, 1'b0, 1'b1, 1);
      offer(REQ_QUERY, 1'b1, 1'b0, 1);

      ones_bias = $urandom_range(95, 5);
      done = 0;
      while (done < RANDOM_ITEMS) begin
         hold_off_due = (done >= 300);
         steady       = (done >= 600 && done < 800);
         pick = $urandom_range(999);
         if (pick < 6) begin
            offer(REQ_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(MAX_BITS));
            ones_bias = $urandom_range(95, 5);
            done++;
         end else if (pick < 30) begin
            // ignored code, not counted
            offer(REQ_IGNORED, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(8191));
         end else if (pick < 520) begin
            offer(REQ_APPEND, $urandom_range(99) < ones_bias, 1'($urandom_range(1)),
                  $urandom_range(MAX_BITS));
            done++;
         end else begin
            want  = 1'($urandom_range(1));
            total = want ? ones_held : zeros_held;
            pick  = $urandom_range(9);
            if (pick == 0)
               offer(REQ_QUERY, 1'($urandom_range(1)), want, 0);
            else if (pick == 1)
               offer(REQ_QUERY, 1'($urandom_range(1)), want,
                     (total + 8 > MAX_BITS) ? MAX_BITS : total + 1 + $urandom_range(7));
            else if (pick == 2 || total == 0)
               offer(REQ_QUERY, 1'($urandom_range(1)), want, $urandom_range(MAX_BITS));
            else
               offer(REQ_QUERY, 1'($urandom_range(1)), want, $urandom_range(total, 1));
            done++;
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      wait (answers_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // result side: random stalls, one long hold-off so the block backs up
   initial begin : drain
      wait (!reset);
      forever begin
         if (hold_off_due && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 18);
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/bssi_pkg.sv
sv/bssi_store.sv
sv/bssi_ctrl.sv
sv/bit_select_sampled_index.sv
verif/bssi_select_checker.sv
verif/bit_select_sampled_index_tb.sv
